// ----- rtl/abts_pkg.sv -----
// shared constants, codes and controller/datapath interface types for the tree store
package abts_pkg;

  localparam int NODES      = 64;
  localparam int VALUE_BITS = 16;
  localparam int ADDR_W     = $clog2(NODES);
  // wide enough for any level/order position and for child indices of any node
  localparam int WIDE_W     = (ADDR_W + 2 > 8) ? ADDR_W + 2 : 8;

  localparam int CMD_W    = 3;
  localparam int LEVEL_W  = 3;
  localparam int ORDER_W  = 7;
  localparam int DATA_W   = 16;
  localparam int STATUS_W = 2;

  // request payload offsets in s_tdata
  localparam int LEVEL_LSB  = 0;
  localparam int ORDER_LSB  = LEVEL_LSB + LEVEL_W;
  localparam int DVAL_LSB   = ORDER_LSB + ORDER_W;
  localparam int S_TDATA_W  = ((DVAL_LSB + DATA_W + 7) / 8) * 8;

  // result payload offsets in m_tdata
  localparam int RES_LSB    = 0;
  localparam int STATUS_LSB = RES_LSB + DATA_W;
  localparam int EMPTY_LSB  = STATUS_LSB + STATUS_W;
  localparam int ROOT_LSB   = EMPTY_LSB + 1;
  localparam int M_USED_W   = ROOT_LSB + DATA_W;
  localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_READ   = 3'd1,
    CMD_ASSIGN = 3'd2,
    CMD_PARENT = 3'd3,
    CMD_LEFT   = 3'd4,
    CMD_RIGHT  = 3'd5,
    CMD_LSIB   = 3'd6,
    CMD_RSIB   = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_REJECT    = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RD_IDX    = 3'd0,
    RD_PARENT = 3'd1,
    RD_LEFT   = 3'd2,
    RD_RIGHT  = 3'd3,
    RD_SCAN   = 3'd4,
    RD_REL    = 3'd5
  } rd_sel_t;

  typedef enum logic [1:0] {
    RES_ZERO  = 2'd0,
    RES_READ  = 2'd1,
    RES_VALUE = 2'd2
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     clear;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     cap_parent;
    logic     cap_left;
    logic     cap_right;
    logic     write;
    logic     scan_start;
    logic     scan_run;
    logic     out_load;
    res_sel_t res_sel;
    status_t  out_status;
  } ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic pos_ok;
    logic val_zero;
    logic root_empty;
    logic assign_ok;
    logic hit;
    logic exhausted;
  } stat_t;

endpackage

// ----- rtl/abts_ram.sv -----
// generic single write port ram with registered read
module abts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/abts_ctrl.sv -----
// controller state machine: sequences reads, assign checks, the search and the response
module abts_ctrl
  import abts_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  output logic  m_tvalid,
  input  logic  m_tready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_DISPATCH = 11'b00000000010,
    S_RD_WAIT  = 11'b00000000100,
    S_A_PAR    = 11'b00000001000,
    S_A_LEFT   = 11'b00000010000,
    S_A_RIGHT  = 11'b00000100000,
    S_A_DEC    = 11'b00001000000,
    S_SCAN     = 11'b00010000000,
    S_REL      = 11'b00100000000,
    S_REL_WAIT = 11'b01000000000,
    S_RESP     = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctrl       = '0;
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.load  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.cmd)
          CMD_CLEAR: begin
            ctrl.clear      = 1'b1;
            ctrl.out_load   = 1'b1;
            ctrl.res_sel    = RES_ZERO;
            ctrl.out_status = ST_OK;
            state_next      = S_RESP;
          end
          CMD_READ: begin
            if (!stat.pos_ok) begin
              ctrl.out_load   = 1'b1;
              ctrl.res_sel    = RES_ZERO;
              ctrl.out_status = ST_RANGE;
              state_next      = S_RESP;
            end else begin
              ctrl.rd_en  = 1'b1;
              ctrl.rd_sel = RD_IDX;
              state_next  = S_RD_WAIT;
            end
          end
          CMD_ASSIGN: begin
            if (!stat.pos_ok) begin
              ctrl.out_load   = 1'b1;
              ctrl.res_sel    = RES_ZERO;
              ctrl.out_status = ST_RANGE;
              state_next      = S_RESP;
            end else begin
              ctrl.rd_en  = 1'b1;
              ctrl.rd_sel = RD_PARENT;
              state_next  = S_A_PAR;
            end
          end
          default: begin
            if (stat.root_empty || stat.val_zero) begin
              ctrl.out_load   = 1'b1;
              ctrl.res_sel    = RES_ZERO;
              ctrl.out_status = ST_NOT_FOUND;
              state_next      = S_RESP;
            end else begin
              ctrl.scan_start = 1'b1;
              state_next      = S_SCAN;
            end
          end
        endcase
      end
      S_RD_WAIT: begin
        ctrl.out_load   = 1'b1;
        ctrl.res_sel    = RES_READ;
        ctrl.out_status = ST_OK;
        state_next      = S_RESP;
      end
      S_A_PAR: begin
        ctrl.cap_parent = 1'b1;
        ctrl.rd_en      = 1'b1;
        ctrl.rd_sel     = RD_LEFT;
        state_next      = S_A_LEFT;
      end
      S_A_LEFT: begin
        ctrl.cap_left = 1'b1;
        ctrl.rd_en    = 1'b1;
        ctrl.rd_sel   = RD_RIGHT;
        state_next    = S_A_RIGHT;
      end
      S_A_RIGHT: begin
        ctrl.cap_right = 1'b1;
        state_next     = S_A_DEC;
      end
      S_A_DEC: begin
        ctrl.out_load = 1'b1;
        if (stat.assign_ok) begin
          ctrl.write      = 1'b1;
          ctrl.res_sel    = RES_VALUE;
          ctrl.out_status = ST_OK;
        end else begin
          ctrl.res_sel    = RES_ZERO;
          ctrl.out_status = ST_REJECT;
        end
        state_next = S_RESP;
      end
      S_SCAN: begin
        // a hit refers to the address issued in the previous cycle, so stop advancing
        priority if (stat.hit) begin
          state_next = S_REL;
        end else if (stat.exhausted) begin
          ctrl.out_load   = 1'b1;
          ctrl.res_sel    = RES_ZERO;
          ctrl.out_status = ST_NOT_FOUND;
          state_next      = S_RESP;
        end else begin
          ctrl.scan_run = 1'b1;
          ctrl.rd_en    = 1'b1;
          ctrl.rd_sel   = RD_SCAN;
        end
      end
      S_REL: begin
        ctrl.rd_en  = 1'b1;
        ctrl.rd_sel = RD_REL;
        state_next  = S_REL_WAIT;
      end
      S_REL_WAIT: begin
        ctrl.out_load   = 1'b1;
        ctrl.res_sel    = RES_READ;
        ctrl.out_status = ST_OK;
        state_next      = S_RESP;
      end
      S_RESP: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/abts_dpath.sv -----
// datapath: request registers, node ram with valid bits, scan counter, result register
module abts_dpath
  import abts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [LEVEL_W-1:0] in_level,
  input  logic [ORDER_W-1:0] in_order,
  input  logic [DATA_W-1:0]  in_data_value,
  input  ctrl_t              ctrl,
  output stat_t              stat,
  output logic [DATA_W-1:0]  result_value,
  output logic [STATUS_W-1:0] status,
  output logic               tree_empty,
  output logic [DATA_W-1:0]  root_value
);

  cmd_t                  cmd_q;
  logic [LEVEL_W-1:0]    level_q;
  logic [ORDER_W-1:0]    order_q;
  logic [VALUE_BITS-1:0] val_q;

  logic [NODES-1:0]      valid;
  logic [VALUE_BITS-1:0] root_reg;
  logic [VALUE_BITS-1:0] par_v;
  logic [VALUE_BITS-1:0] left_v;
  logic [VALUE_BITS-1:0] right_v;
  logic [WIDE_W-1:0]     scan_addr;
  logic                  cmp_vld;
  logic [ADDR_W-1:0]     cmp_idx;
  logic                  rd_ok_q;
  logic [VALUE_BITS-1:0] res_q;
  status_t               status_q;

  logic [WIDE_W-1:0]     width;
  logic [WIDE_W-1:0]     idx;
  logic                  pos_ok;
  logic [WIDE_W-1:0]     found;
  logic [WIDE_W-1:0]     rel_addr;
  logic [WIDE_W-1:0]     rd_wide;
  logic                  rd_in_range;
  logic [ADDR_W-1:0]     rd_addr;
  logic [VALUE_BITS-1:0] rd_data;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  step_two;
  logic [WIDE_W-1:0]     scan_first;

  // position decode: index = 2^(level-1) + order - 2
  always_comb begin
    width  = WIDE_W'(1) << (level_q - LEVEL_W'(1));
    idx    = width + WIDE_W'(order_q) - WIDE_W'(2);
    pos_ok = (level_q != '0) && (order_q != '0) && (WIDE_W'(order_q) <= width) &&
             (idx < WIDE_W'(NODES));
  end

  // relative of the matched node
  always_comb begin
    found = WIDE_W'(cmp_idx);
    unique case (cmd_q)
      CMD_PARENT: rel_addr = (found - WIDE_W'(1)) >> 1;
      CMD_LEFT:   rel_addr = (found << 1) + WIDE_W'(1);
      CMD_RIGHT:  rel_addr = (found << 1) + WIDE_W'(2);
      CMD_LSIB:   rel_addr = found - WIDE_W'(1);
      default:    rel_addr = found + WIDE_W'(1);
    endcase
  end

  always_comb begin
    unique case (ctrl.rd_sel)
      RD_IDX:    rd_wide = idx;
      RD_PARENT: rd_wide = (idx - WIDE_W'(1)) >> 1;
      RD_LEFT:   rd_wide = (idx << 1) + WIDE_W'(1);
      RD_RIGHT:  rd_wide = (idx << 1) + WIDE_W'(2);
      RD_SCAN:   rd_wide = scan_addr;
      RD_REL:    rd_wide = rel_addr;
      default:   rd_wide = idx;
    endcase
    rd_in_range = rd_wide < WIDE_W'(NODES);
    rd_addr     = rd_wide[ADDR_W-1:0];
  end

  always_comb begin
    step_two = (cmd_q == CMD_LSIB) || (cmd_q == CMD_RSIB);
    unique case (cmd_q)
      CMD_PARENT, CMD_RSIB: scan_first = WIDE_W'(1);
      CMD_LSIB:             scan_first = WIDE_W'(2);
      default:              scan_first = '0;
    endcase
  end

  abts_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(NODES)
  ) u_ram (
    .clk  (clk),
    .we   (ctrl.write),
    .waddr(idx[ADDR_W-1:0]),
    .wdata(val_q),
    .re   (ctrl.rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // never-written or cleared entries read as empty
  assign rd_val = rd_ok_q ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      root_reg <= '0;
      cmp_vld  <= 1'b0;
      rd_ok_q  <= 1'b0;
    end else begin
      if (ctrl.rd_en) begin
        rd_ok_q <= rd_in_range && valid[rd_addr];
      end
      if (ctrl.clear) begin
        valid    <= '0;
        root_reg <= '0;
      end else if (ctrl.write) begin
        valid[idx[ADDR_W-1:0]] <= 1'b1;
        if (idx == '0) begin
          root_reg <= val_q;
        end
      end
      if (ctrl.scan_start) begin
        cmp_vld <= 1'b0;
      end else if (ctrl.scan_run) begin
        cmp_vld <= scan_addr < WIDE_W'(NODES);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q   <= cmd_t'(in_cmd);
      level_q <= in_level;
      order_q <= in_order;
      val_q   <= VALUE_BITS'(in_data_value);
    end
    if (ctrl.cap_parent) begin
      par_v <= rd_val;
    end
    if (ctrl.cap_left) begin
      left_v <= rd_val;
    end
    if (ctrl.cap_right) begin
      right_v <= rd_val;
    end
    if (ctrl.scan_start) begin
      scan_addr <= scan_first;
    end else if (ctrl.scan_run) begin
      cmp_idx   <= scan_addr[ADDR_W-1:0];
      scan_addr <= scan_addr + (step_two ? WIDE_W'(2) : WIDE_W'(1));
    end
    if (ctrl.out_load) begin
      unique case (ctrl.res_sel)
        RES_READ:  res_q <= rd_val;
        RES_VALUE: res_q <= val_q;
        default:   res_q <= '0;
      endcase
      status_q <= ctrl.out_status;
    end
  end

  always_comb begin
    stat.cmd        = cmd_q;
    stat.pos_ok     = pos_ok;
    stat.val_zero   = val_q == '0;
    stat.root_empty = root_reg == '0;
    stat.assign_ok  = !(((val_q != '0) && (idx != '0) && (par_v == '0)) ||
                        ((val_q == '0) && ((left_v != '0) || (right_v != '0))));
    stat.hit        = cmp_vld && (rd_val == val_q);
    stat.exhausted  = !cmp_vld && (scan_addr >= WIDE_W'(NODES));
  end

  assign result_value = DATA_W'(res_q);
  assign status       = status_q;
  assign tree_empty   = root_reg == '0;
  assign root_value   = DATA_W'(root_reg);

endmodule

// ----- rtl/array_binary_tree_store_core.sv -----
// array binary tree store: one request at a time, result held until taken
// relation search reads one node per cycle through the ram read port
// next request is taken the cycle after the result is taken
// rst is synchronous: the valid bits and root register clear at once, so no clearing pass
module array_binary_tree_store_core
  import abts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // level, order, data_value, zero pad
  input  logic [CMD_W-1:0]     s_tuser,  // cmd
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata   // result_value, status, tree_empty, root_value, zero pad
);

  ctrl_t                ctrl;
  stat_t                stat;
  logic [DATA_W-1:0]    result_value;
  logic [STATUS_W-1:0]  status;
  logic                 tree_empty;
  logic [DATA_W-1:0]    root_value;

  abts_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  abts_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .in_cmd       (s_tuser),
    .in_level     (s_tdata[LEVEL_LSB +: LEVEL_W]),
    .in_order     (s_tdata[ORDER_LSB +: ORDER_W]),
    .in_data_value(s_tdata[DVAL_LSB +: DATA_W]),
    .ctrl         (ctrl),
    .stat         (stat),
    .result_value (result_value),
    .status       (status),
    .tree_empty   (tree_empty),
    .root_value   (root_value)
  );

  always_comb begin
    m_tdata                           = '0;
    m_tdata[RES_LSB +: DATA_W]        = result_value;
    m_tdata[STATUS_LSB +: STATUS_W]   = status;
    m_tdata[EMPTY_LSB]                = tree_empty;
    m_tdata[ROOT_LSB +: DATA_W]       = root_value;
  end

endmodule
